[rtl/dht_pkg.sv]
package dht_pkg;

  // Hash word and djb2 constants
  localparam int unsigned HASH_W     = 64;
  localparam int unsigned HASH_SHIFT = 5;
  localparam logic [HASH_W-1:0] HASH_START = 64'd5381;

  // Default table depths
  localparam int unsigned KNOWN_DEPTH_DEF = 256;
  localparam int unsigned ADDED_DEPTH_DEF = 256;

  // Input command codes
  localparam logic CMD_PRELOAD = 1'b0;
  localparam logic CMD_NAME    = 1'b1;

  typedef logic [HASH_W-1:0] hash_t;

endpackage

[rtl/dht_hash_fold.sv]
module dht_hash_fold (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fold_en,
  input  logic          name_end,
  input  logic [7:0]    name_byte,
  output dht_pkg::hash_t fold_hash
);

  dht_pkg::hash_t hash_r;
  dht_pkg::hash_t hash_nxt;
  dht_pkg::hash_t byte_ext;

  // Fold one sign-extended byte: hash * 33 + byte
  always_comb begin
    byte_ext  = {{(dht_pkg::HASH_W-8){name_byte[7]}}, name_byte};
    fold_hash = (hash_r << dht_pkg::HASH_SHIFT) + hash_r + byte_ext;
  end

  // Advance on a name beat, restart after the last byte
  always_comb begin
    hash_nxt = hash_r;
    if (fold_en) begin
      hash_nxt = name_end ? dht_pkg::HASH_START : fold_hash;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= dht_pkg::HASH_START;
    end else begin
      hash_r <= hash_nxt;
    end
  end

endmodule

[rtl/dht_known_mem.sv]
module dht_known_mem #(
  parameter int unsigned DEPTH = dht_pkg::KNOWN_DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  dht_pkg::hash_t wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output dht_pkg::hash_t rd_data,
  output logic [CW-1:0]  count,
  output logic           dropped
);

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  dht_pkg::hash_t mem [DEPTH];
  dht_pkg::hash_t rd_data_r;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic           dropped_r;
  logic           dropped_nxt;
  logic           room;

  assign room = (count_r < DEPTH_C);

  // Append while there is room, else set the sticky drop flag
  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    if (wr_en) begin
      if (room) begin
        count_nxt = count_r + 1'b1;
      end else begin
        dropped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en && room) begin
      mem[count_r[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign count   = count_r;
  assign dropped = dropped_r;

endmodule

[rtl/dht_added_mem.sv]
module dht_added_mem #(
  parameter int unsigned DEPTH = dht_pkg::ADDED_DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           app_en,
  input  dht_pkg::hash_t app_data,
  output logic           full
);

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  dht_pkg::hash_t mem [DEPTH];
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic           room;

  assign room = (count_r < DEPTH_C);
  assign full = !room;

  // Saturate the fill count at the table depth
  always_comb begin
    count_nxt = count_r;
    if (app_en && room) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Store the new hash at the fill point
  always_ff @(posedge clk) begin
    if (app_en && room) begin
      mem[count_r[AW-1:0]] <= app_data;
    end
  end

endmodule

[rtl/name_hash_dedupe_table.sv]
// Name hash dedupe table.
// Input channel: an item is taken at a clock edge with start high and busy
// low. in_cmd selects a preload of in_known_value into the known table or
// one name byte (in_name_byte, in_name_end marks the last byte).
// A preload or a non-final name byte is taken while busy stays low.
// On the last byte the finished djb2 hash is compared with the N stored
// known entries, one entry a cycle through the table's single read port
// and one shared comparator, with busy high until the result beat is posted.
// The result beat (out_strobe with out_name_hash, out_is_new,
// out_added_full, out_known_dropped) shows for one cycle, registered from the
// finish step; a new item may be taken in that same cycle.
// New hashes go into the added table until it is full.
// The receiver cannot stall: each beat is taken when it shows.
// Reset (synchronous, active low) empties both tables by clearing their
// fill counts, clears the sticky drop flag and restarts the hash at 5381;
// no clearing pass is needed.
module name_hash_dedupe_table #(
  parameter int unsigned KNOWN_DEPTH = dht_pkg::KNOWN_DEPTH_DEF,
  parameter int unsigned ADDED_DEPTH = dht_pkg::ADDED_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [7:0]  in_name_byte,
  input  logic        in_name_end,
  input  logic [63:0] in_known_value,
  output logic        out_strobe,
  output logic [63:0] out_name_hash,
  output logic        out_is_new,
  output logic        out_added_full,
  output logic        out_known_dropped
);

  localparam int unsigned KAW = (KNOWN_DEPTH > 1) ? $clog2(KNOWN_DEPTH) : 1;
  localparam int unsigned KCW = $clog2(KNOWN_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  logic [KCW-1:0] idx_r, idx_nxt;
  logic           rd_vld_r, rd_vld_nxt;
  logic           hit_r, hit_nxt;
  dht_pkg::hash_t hash_r, hash_nxt;
  logic           strobe_r, strobe_nxt;
  dht_pkg::hash_t o_hash_r, o_hash_nxt;
  logic           o_new_r, o_new_nxt;
  logic           o_full_r, o_full_nxt;
  logic           o_drop_r, o_drop_nxt;

  logic           accept;
  logic           pre_en;
  logic           name_en;
  logic           rd_en;
  dht_pkg::hash_t fold_hash;
  dht_pkg::hash_t rd_data;
  logic [KCW-1:0] known_count;
  logic           known_dropped;
  logic           app_en;
  logic           added_full;

  assign accept  = start && !busy;
  assign pre_en  = accept && (in_cmd == dht_pkg::CMD_PRELOAD);
  assign name_en = accept && (in_cmd == dht_pkg::CMD_NAME);
  assign busy    = (state_r != ST_IDLE);

  dht_hash_fold u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .fold_en   (name_en),
    .name_end  (in_name_end),
    .name_byte (in_name_byte),
    .fold_hash (fold_hash)
  );

  dht_known_mem #(
    .DEPTH (KNOWN_DEPTH)
  ) u_known (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (pre_en),
    .wr_data (in_known_value),
    .rd_en   (rd_en),
    .rd_addr (idx_r[KAW-1:0]),
    .rd_data (rd_data),
    .count   (known_count),
    .dropped (known_dropped)
  );

  dht_added_mem #(
    .DEPTH (ADDED_DEPTH)
  ) u_added (
    .clk      (clk),
    .rst_n    (rst_n),
    .app_en   (app_en),
    .app_data (hash_r),
    .full     (added_full)
  );

  // Issue one read a cycle while entries remain
  assign rd_en  = (state_r == ST_SCAN) && (idx_r != known_count);
  assign app_en = (state_r == ST_FINISH) && !hit_r;

  // Sequencer: scan the known table, then post the result beat
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    rd_vld_nxt = 1'b0;
    hit_nxt    = hit_r;
    hash_nxt   = hash_r;
    strobe_nxt = 1'b0;
    o_hash_nxt = o_hash_r;
    o_new_nxt  = o_new_r;
    o_full_nxt = o_full_r;
    o_drop_nxt = o_drop_r;
    unique case (state_r)
      ST_IDLE: begin
        if (name_en && in_name_end) begin
          hash_nxt  = fold_hash;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Shared comparator checks the entry read last cycle
        if (rd_vld_r && (rd_data == hash_r)) begin
          hit_nxt = 1'b1;
        end
        if (rd_en) begin
          idx_nxt    = idx_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        strobe_nxt = 1'b1;
        o_hash_nxt = hash_r;
        o_new_nxt  = !hit_r;
        o_full_nxt = !hit_r && added_full;
        o_drop_nxt = known_dropped;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_vld_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Scan and result payload
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    hit_r    <= hit_nxt;
    hash_r   <= hash_nxt;
    o_hash_r <= o_hash_nxt;
    o_new_r  <= o_new_nxt;
    o_full_r <= o_full_nxt;
    o_drop_r <= o_drop_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_name_hash     = o_hash_r;
  assign out_is_new        = o_new_r;
  assign out_added_full    = o_full_r;
  assign out_known_dropped = o_drop_r;

`ifndef SYNTHESIS
  // A final name byte always starts a scan
  a_end_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == dht_pkg::CMD_NAME && in_name_end) |=> busy)
    else $error("final name byte did not start a scan");

  // The result beat follows the finish step
  a_strobe_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == ST_FINISH) && !busy)
    else $error("result beat outside the finish step");

  // A known hash never reports a full added table
  a_full_only_new: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_is_new) |-> !out_added_full)
    else $error("added_full set on a known hash");

  // Pending reads exist only during the scan
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SCAN))
    else $error("read data pending outside scan");
`endif

endmodule
